### rtl/core/assert_macros.svh
// assertion macros shared by the blocks of the sensor average history unit
// no dependencies; taken in by `include where a module checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SAVH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SAVH_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SAVH_ASSERT(label, clk, rst, prop, msg)
`define SAVH_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

### rtl/core/savh_pkg.sv
// types, constants and width helpers of the sensor average history unit
// no dependencies; used by every other file but savh_stream_if and assert_macros.svh
package savh_pkg;

   localparam int HISTORY_DEPTH_DEFAULT     = 30;
   localparam int SAMPLES_PER_POINT_DEFAULT = 60;
   localparam int QUEUE_DEPTH               = 2;

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        chamber_tvoc;
      logic [15:0]        chamber_eco2;
      logic signed [7:0]  chamber_temp;
      logic [6:0]         chamber_rh;
      logic [15:0]        room_tvoc;
      logic [15:0]        room_eco2;
      logic signed [7:0]  room_temp;
      logic [6:0]         room_rh;
      logic [4:0]         age_index;
   } req_item_type;

   typedef struct packed {
      logic [15:0]        avg_chamber_tvoc;
      logic [15:0]        avg_chamber_eco2;
      logic signed [7:0]  avg_chamber_temp;
      logic [6:0]         avg_chamber_rh;
      logic [15:0]        avg_room_tvoc;
      logic [15:0]        avg_room_eco2;
      logic signed [7:0]  avg_room_temp;
      logic [6:0]         avg_room_rh;
   } point_type;

   typedef struct packed {
      logic [15:0]        avg_chamber_tvoc;
      logic [15:0]        avg_chamber_eco2;
      logic signed [7:0]  avg_chamber_temp;
      logic [6:0]         avg_chamber_rh;
      logic [15:0]        avg_room_tvoc;
      logic [15:0]        avg_room_eco2;
      logic signed [7:0]  avg_room_temp;
      logic [6:0]         avg_room_rh;
      logic               point_written;
      logic               entry_valid;
      logic [4:0]         points_stored;
      logic [5:0]         samples_pending;
   } rsp_item_type;

   // classified word handed from front to back
   typedef struct packed {
      logic               is_read;
      logic               finish;
      logic               entry_valid;
      logic [4:0]         points_stored;
      logic [5:0]         samples_pending;
   } ctrl_type;

   function automatic int count_width(input int spp);
      return $clog2(spp + 1);
   endfunction

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

### rtl/core/savh_stream_if.sv
// valid/ready channel carrying one word of a given payload type
// depends on nothing; payload types come from savh_pkg
interface savh_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/sensor_average_history_unit.sv
// Boxcar averages with a history ring. One word is taken per cycle while results are
// taken, and each word gives one result word after the back end's sum, quotient and
// result stages; the rate is set by the front end's running-sum update, and each word
// needs at most one history ram write or read. A two-word queue parts the front end
// (sums, counters, ring pointers) from the back end (constant-reciprocal division,
// history ram, result register), so either side may stall alone. The ring needs no
// clearing pass after reset: the fill count marks which points are valid.
//
// depends on savh_pkg, savh_stream_if, savh_front, savh_queue, savh_back, savh_ram
module sensor_average_history_unit #(
   parameter int HISTORY_DEPTH     = savh_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int SAMPLES_PER_POINT = savh_pkg::SAMPLES_PER_POINT_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   savh_stream_if.sink   req_bus,
   savh_stream_if.source rsp_bus
);

   localparam int CNT_W  = savh_pkg::count_width(SAMPLES_PER_POINT);
   localparam int TE_W   = 16 + CNT_W;
   localparam int TP_W   = 8 + CNT_W;
   localparam int RH_W   = 7 + CNT_W;
   localparam int ADDR_W = savh_pkg::addr_width(HISTORY_DEPTH);
   localparam int CMD_W  = $bits(savh_pkg::ctrl_type) + ADDR_W + 4 * TE_W + 2 * TP_W
                         + 2 * RH_W;

   logic                 push, pop, q_full, q_valid;
   savh_pkg::ctrl_type   f_ctrl, b_ctrl;
   logic [ADDR_W-1:0]    f_addr, b_addr;
   logic [3:0][TE_W-1:0] f_te, b_te;
   logic [1:0][TP_W-1:0] f_tp, b_tp;
   logic [1:0][RH_W-1:0] f_rh, b_rh;
   logic [CMD_W-1:0]     q_wdata, q_rdata;

   savh_front #(
      .HISTORY_DEPTH     (HISTORY_DEPTH),
      .SAMPLES_PER_POINT (SAMPLES_PER_POINT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (q_full),
      .push       (push),
      .push_ctrl  (f_ctrl),
      .push_addr  (f_addr),
      .push_te    (f_te),
      .push_tp    (f_tp),
      .push_rh    (f_rh)
   );

   assign q_wdata = {f_ctrl, f_addr, f_te, f_tp, f_rh};

   savh_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (q_wdata),
      .full   (q_full),
      .rvalid (q_valid),
      .rdata  (q_rdata),
      .pop    (pop)
   );

   assign {b_ctrl, b_addr, b_te, b_tp, b_rh} = q_rdata;

   savh_back #(
      .HISTORY_DEPTH     (HISTORY_DEPTH),
      .SAMPLES_PER_POINT (SAMPLES_PER_POINT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ctrl  (b_ctrl),
      .q_addr  (b_addr),
      .q_te    (b_te),
      .q_tp    (b_tp),
      .q_rh    (b_rh),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

### rtl/core/savh_ram.sv
// generic single write port, single read port ram with registered read data
// depends on savh_pkg for the address width helper
module savh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_W = savh_pkg::addr_width(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/savh_queue.sv
// short first-in first-out queue of classified words between front and back
// depends on savh_pkg for the queue depth
module savh_queue #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   output logic             rvalid,
   output logic [WIDTH-1:0] rdata,
   input  logic             pop
);

   localparam int PTR_W = savh_pkg::addr_width(savh_pkg::QUEUE_DEPTH);
   localparam int LVL_W = $clog2(savh_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [savh_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(savh_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(savh_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   level_in = level_ff + LVL_W'(1);
         2'b01:   level_in = level_ff - LVL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign full   = (level_ff == LVL_W'(savh_pkg::QUEUE_DEPTH));
   assign rvalid = (level_ff != '0);
   assign rdata  = slot_ff[rd_ptr_ff];

endmodule

### rtl/core/savh_front.sv
// front end: accepts words, keeps the running sums and ring bookkeeping,
// classifies each word for the back end; depends on savh_pkg and savh_stream_if
`include "assert_macros.svh"
module savh_front #(
   parameter int HISTORY_DEPTH     = savh_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int SAMPLES_PER_POINT = savh_pkg::SAMPLES_PER_POINT_DEFAULT,
   localparam int CNT_W  = savh_pkg::count_width(SAMPLES_PER_POINT),
   localparam int TE_W   = 16 + CNT_W,
   localparam int TP_W   = 8 + CNT_W,
   localparam int RH_W   = 7 + CNT_W,
   localparam int ADDR_W = savh_pkg::addr_width(HISTORY_DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   savh_stream_if.sink              req_bus,
   input  logic                     queue_full,
   output logic                     push,
   output savh_pkg::ctrl_type       push_ctrl,
   output logic [ADDR_W-1:0]        push_addr,
   output logic [3:0][TE_W-1:0]     push_te,
   output logic [1:0][TP_W-1:0]     push_tp,
   output logic [1:0][RH_W-1:0]     push_rh
);

   localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W  = FILL_W + 1;
   localparam int CMP_W  = (FILL_W > 5) ? FILL_W : 5;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_POINT - 1);

   logic [3:0][TE_W-1:0] te_sum_ff, te_sum_in, te_add;
   logic [1:0][TP_W-1:0] tp_sum_ff, tp_sum_in, tp_add;
   logic [1:0][RH_W-1:0] rh_sum_ff, rh_sum_in, rh_add;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ADDR_W-1:0]    wp_ff, wp_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;

   logic                 is_read;
   logic                 finish;
   logic                 hit;
   logic [IDX_W-1:0]     idx_sum;
   logic [IDX_W-1:0]     idx_wrap;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && req_bus.ready;

   always_comb begin
      is_read = (req_bus.payload.kind == savh_pkg::KIND_READ);
      finish  = !is_read && (cnt_ff == CNT_LAST);

      te_add[0] = te_sum_ff[0] + TE_W'(req_bus.payload.chamber_tvoc);
      te_add[1] = te_sum_ff[1] + TE_W'(req_bus.payload.chamber_eco2);
      te_add[2] = te_sum_ff[2] + TE_W'(req_bus.payload.room_tvoc);
      te_add[3] = te_sum_ff[3] + TE_W'(req_bus.payload.room_eco2);
      tp_add[0] = tp_sum_ff[0] + TP_W'(req_bus.payload.chamber_temp);
      tp_add[1] = tp_sum_ff[1] + TP_W'(req_bus.payload.room_temp);
      rh_add[0] = rh_sum_ff[0] + RH_W'(req_bus.payload.chamber_rh);
      rh_add[1] = rh_sum_ff[1] + RH_W'(req_bus.payload.room_rh);

      te_sum_in = te_sum_ff;
      tp_sum_in = tp_sum_ff;
      rh_sum_in = rh_sum_ff;
      cnt_in    = cnt_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      if (push && !is_read) begin
         if (finish) begin
            te_sum_in = '0;
            tp_sum_in = '0;
            rh_sum_in = '0;
            cnt_in    = '0;
            wp_in     = (wp_ff == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + ADDR_W'(1);
            if (fill_ff < FILL_W'(HISTORY_DEPTH)) begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end else begin
            te_sum_in = te_add;
            tp_sum_in = tp_add;
            rh_sum_in = rh_add;
            cnt_in    = cnt_ff + CNT_W'(1);
         end
      end

      // oldest point sits fill_count places behind the write pointer
      hit      = is_read && (CMP_W'(req_bus.payload.age_index) < CMP_W'(fill_ff));
      idx_sum  = IDX_W'(wp_ff) + IDX_W'(HISTORY_DEPTH) - IDX_W'(fill_ff)
               + IDX_W'(req_bus.payload.age_index);
      idx_wrap = (idx_sum >= IDX_W'(HISTORY_DEPTH)) ? idx_sum - IDX_W'(HISTORY_DEPTH)
                                                    : idx_sum;

      push_ctrl.is_read         = is_read;
      push_ctrl.finish          = finish;
      push_ctrl.entry_valid     = hit;
      push_ctrl.points_stored   = 5'(fill_in);
      push_ctrl.samples_pending = 6'(cnt_in);
      push_addr = is_read ? ADDR_W'(idx_wrap) : wp_ff;
      push_te   = te_add;
      push_tp   = tp_add;
      push_rh   = rh_add;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         te_sum_ff <= '0;
         tp_sum_ff <= '0;
         rh_sum_ff <= '0;
         cnt_ff    <= '0;
         wp_ff     <= '0;
         fill_ff   <= '0;
      end else begin
         te_sum_ff <= te_sum_in;
         tp_sum_ff <= tp_sum_in;
         rh_sum_ff <= rh_sum_in;
         cnt_ff    <= cnt_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
      end
   end

   `SAVH_ASSERT(a_fill_range, clock, reset, fill_ff <= FILL_W'(HISTORY_DEPTH), "fill count beyond depth")
   `SAVH_ASSERT(a_clear_after_point, clock, reset, push && push_ctrl.finish |=> cnt_ff == '0 && te_sum_ff == '0, "sums not cleared after a point")

endmodule

### rtl/core/savh_back.sv
// back end: divides finished sums, writes and reads the history ram,
// holds the result word; depends on savh_pkg, savh_stream_if and savh_ram
`include "assert_macros.svh"
module savh_back #(
   parameter int HISTORY_DEPTH     = savh_pkg::HISTORY_DEPTH_DEFAULT,
   parameter int SAMPLES_PER_POINT = savh_pkg::SAMPLES_PER_POINT_DEFAULT,
   localparam int CNT_W  = savh_pkg::count_width(SAMPLES_PER_POINT),
   localparam int TE_W   = 16 + CNT_W,
   localparam int TP_W   = 8 + CNT_W,
   localparam int RH_W   = 7 + CNT_W,
   localparam int ADDR_W = savh_pkg::addr_width(HISTORY_DEPTH)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  savh_pkg::ctrl_type   q_ctrl,
   input  logic [ADDR_W-1:0]    q_addr,
   input  logic [3:0][TE_W-1:0] q_te,
   input  logic [1:0][TP_W-1:0] q_tp,
   input  logic [1:0][RH_W-1:0] q_rh,
   output logic                 pop,
   savh_stream_if.source        rsp_bus
);

   localparam int POINT_W = $bits(savh_pkg::point_type);
   localparam int DIV_N   = TE_W;
   localparam int DIV_L   = $clog2(SAMPLES_PER_POINT);
   // reciprocal rounded up, exact for every dividend below 2**DIV_N
   localparam logic [DIV_N:0] DIV_M = (DIV_N + 1)'(
      ((64'd1 << (DIV_N + DIV_L)) + 64'(SAMPLES_PER_POINT) - 64'd1) / 64'(SAMPLES_PER_POINT));

   function automatic logic [15:0] div_spp(input logic [DIV_N-1:0] n);
      logic [2*DIV_N:0] p;
      p = n * DIV_M;
      return 16'(p >> (DIV_N + DIV_L));
   endfunction

   // stage 1: sums
   logic                 v1_ff, v1_in;
   savh_pkg::ctrl_type   ctrl1_ff;
   logic [ADDR_W-1:0]    addr1_ff;
   logic [3:0][TE_W-1:0] te1_ff;
   logic [1:0][TP_W-1:0] tp1_ff;
   logic [1:0][RH_W-1:0] rh1_ff;

   // stage 2: quotients
   logic                 v2_ff, v2_in;
   savh_pkg::ctrl_type   ctrl2_ff;
   logic [ADDR_W-1:0]    addr2_ff;
   logic [3:0][15:0]     teq2_ff, teq_in;
   logic [1:0][7:0]      tpq2_ff, tpq_in;
   logic [1:0]           tneg2_ff, tneg_in;
   logic [1:0][6:0]      rhq2_ff, rhq_in;

   // stage 3: result word
   logic                 v3_ff, v3_in;
   savh_pkg::ctrl_type   ctrl3_ff;
   savh_pkg::point_type  point3_ff;

   logic [1:0][TP_W-1:0] tmag;
   savh_pkg::point_type  point2;
   savh_pkg::point_type  avg;
   logic                 ld1, ld2, ld3;
   logic                 ram_we, ram_re;
   logic [POINT_W-1:0]   ram_rdata;

   always_comb begin
      ld3 = !v3_ff || rsp_bus.ready;
      ld2 = !v2_ff || ld3;
      ld1 = !v1_ff || ld2;
      pop = q_valid && ld1;
      v1_in = ld1 ? pop : v1_ff;
      v2_in = ld2 ? v1_ff : v2_ff;
      v3_in = ld3 ? v2_ff : v3_ff;
      ram_we = v2_ff && ld3 && ctrl2_ff.finish;
      ram_re = v2_ff && ld3 && ctrl2_ff.is_read && ctrl2_ff.entry_valid;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         teq_in[i] = div_spp(te1_ff[i]);
      end
      for (int i = 0; i < 2; i++) begin
         tneg_in[i] = tp1_ff[i][TP_W-1];
         tmag[i]    = tneg_in[i] ? -tp1_ff[i] : tp1_ff[i];
         tpq_in[i]  = 8'(div_spp(DIV_N'(tmag[i])));
         rhq_in[i]  = 7'(div_spp(DIV_N'(rh1_ff[i])));
      end
   end

   always_comb begin
      point2.avg_chamber_tvoc = teq2_ff[0];
      point2.avg_chamber_eco2 = teq2_ff[1];
      point2.avg_chamber_temp = tneg2_ff[0] ? -tpq2_ff[0] : tpq2_ff[0];
      point2.avg_chamber_rh   = rhq2_ff[0];
      point2.avg_room_tvoc    = teq2_ff[2];
      point2.avg_room_eco2    = teq2_ff[3];
      point2.avg_room_temp    = tneg2_ff[1] ? -tpq2_ff[1] : tpq2_ff[1];
      point2.avg_room_rh      = rhq2_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) begin
         ctrl1_ff <= q_ctrl;
         addr1_ff <= q_addr;
         te1_ff   <= q_te;
         tp1_ff   <= q_tp;
         rh1_ff   <= q_rh;
      end
      if (ld2) begin
         ctrl2_ff <= ctrl1_ff;
         addr2_ff <= addr1_ff;
         teq2_ff  <= teq_in;
         tpq2_ff  <= tpq_in;
         tneg2_ff <= tneg_in;
         rhq2_ff  <= rhq_in;
      end
      if (ld3) begin
         ctrl3_ff  <= ctrl2_ff;
         point3_ff <= ctrl2_ff.finish ? point2 : '0;
      end
   end

   savh_ram #(
      .WIDTH (POINT_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr2_ff),
      .wr_data (point2),
      .rd_en   (ram_re),
      .rd_addr (addr2_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (ctrl3_ff.is_read) begin
         avg = ctrl3_ff.entry_valid ? savh_pkg::point_type'(ram_rdata) : '0;
      end else begin
         avg = point3_ff;
      end
      rsp_bus.valid                    = v3_ff;
      rsp_bus.payload.avg_chamber_tvoc = avg.avg_chamber_tvoc;
      rsp_bus.payload.avg_chamber_eco2 = avg.avg_chamber_eco2;
      rsp_bus.payload.avg_chamber_temp = avg.avg_chamber_temp;
      rsp_bus.payload.avg_chamber_rh   = avg.avg_chamber_rh;
      rsp_bus.payload.avg_room_tvoc    = avg.avg_room_tvoc;
      rsp_bus.payload.avg_room_eco2    = avg.avg_room_eco2;
      rsp_bus.payload.avg_room_temp    = avg.avg_room_temp;
      rsp_bus.payload.avg_room_rh      = avg.avg_room_rh;
      rsp_bus.payload.point_written    = ctrl3_ff.finish;
      rsp_bus.payload.entry_valid      = ctrl3_ff.entry_valid;
      rsp_bus.payload.points_stored    = ctrl3_ff.points_stored;
      rsp_bus.payload.samples_pending  = ctrl3_ff.samples_pending;
   end

   `SAVH_ASSERT_NEVER(a_hold_read_data, clock, reset, v3_ff && !rsp_bus.ready && ram_re, "history read while result word held")
   `SAVH_ASSERT(a_flags_exclusive, clock, reset, rsp_bus.valid |-> !(rsp_bus.payload.point_written && rsp_bus.payload.entry_valid), "point written on a read word")
   `SAVH_ASSERT(a_idle_sample_zero, clock, reset, v3_ff && !ctrl3_ff.is_read && !ctrl3_ff.finish |-> point3_ff == '0, "averages on a sample that stored no point")

endmodule

### test/sensor_average_history_unit_tb.sv
// testbench for sensor_average_history_unit: random sample and read words against a
// predictor of the averages and the history ring, with random stalls on both channels
// depends on savh_pkg, savh_stream_if and the rtl of sensor_average_history_unit
`timescale 1ns / 100ps

module sensor_average_history_unit_tb;

   localparam int HIST = savh_pkg::HISTORY_DEPTH_DEFAULT;
   localparam int SPP  = savh_pkg::SAMPLES_PER_POINT_DEFAULT;

   typedef enum int {
      MIX_RANDOM,
      MIX_HIGH,
      MIX_LOW,
      MIX_NEAR_ZERO
   } mix_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   savh_pkg::req_item_type req_word = '0;
   logic                   rsp_ready = 1'b0;
   logic                   req_taken = 1'b0;

   savh_stream_if #(.payload_type(savh_pkg::req_item_type)) req_bus ();
   savh_stream_if #(.payload_type(savh_pkg::rsp_item_type)) rsp_bus ();

   assign req_bus.valid   = req_valid;
   assign req_bus.payload = req_word;
   assign rsp_bus.ready   = rsp_ready;

   sensor_average_history_unit #(
      .HISTORY_DEPTH(HIST),
      .SAMPLES_PER_POINT(SPP)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #5 clock = ~clock;

   // predictor state
   int unsigned         flow_sum [4];
   int                  temp_sum [2];
   int unsigned         rh_sum [2];
   int unsigned         samples_taken;
   savh_pkg::point_type ring [HIST];
   int unsigned         next_slot;
   int unsigned         points_held;

   savh_pkg::req_item_type sensor_words [$];
   savh_pkg::rsp_item_type predicted_results [$];
   int           total_words;
   int           words_accepted = 0;
   int           results_seen = 0;
   int           mismatches = 0;
   int           send_gap = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   bit           hold_done = 1'b0;

   function automatic savh_pkg::rsp_item_type average_and_store(
         input savh_pkg::req_item_type w);
      savh_pkg::point_type p;
      logic                written;
      logic                valid;
      p = '0;
      written = 1'b0;
      valid = 1'b0;
      if (w.kind == savh_pkg::KIND_SAMPLE) begin
         flow_sum[0] += w.chamber_tvoc;
         flow_sum[1] += w.chamber_eco2;
         flow_sum[2] += w.room_tvoc;
         flow_sum[3] += w.room_eco2;
         temp_sum[0] += $signed(w.chamber_temp);
         temp_sum[1] += $signed(w.room_temp);
         rh_sum[0] += w.chamber_rh;
         rh_sum[1] += w.room_rh;
         samples_taken++;
         if (samples_taken >= SPP) begin
            p.avg_chamber_tvoc = 16'(flow_sum[0] / SPP);
            p.avg_chamber_eco2 = 16'(flow_sum[1] / SPP);
            p.avg_chamber_temp = 8'(temp_sum[0] / SPP);
            p.avg_chamber_rh   = 7'(rh_sum[0] / SPP);
            p.avg_room_tvoc    = 16'(flow_sum[2] / SPP);
            p.avg_room_eco2    = 16'(flow_sum[3] / SPP);
            p.avg_room_temp    = 8'(temp_sum[1] / SPP);
            p.avg_room_rh      = 7'(rh_sum[1] / SPP);
            ring[next_slot] = p;
            next_slot = (next_slot + 1) % HIST;
            if (points_held < HIST) points_held++;
            flow_sum = '{default: 0};
            temp_sum = '{default: 0};
            rh_sum = '{default: 0};
            samples_taken = 0;
            written = 1'b1;
         end
      end else if (w.age_index < points_held) begin
         p = ring[(next_slot + HIST - points_held + w.age_index) % HIST];
         valid = 1'b1;
      end
      return savh_pkg::rsp_item_type'({p, written, valid, 5'(points_held),
                                       6'(samples_taken)});
   endfunction

   function automatic savh_pkg::req_item_type sample_word(input mix_type mix);
      logic [127:0]           bits;
      savh_pkg::req_item_type w;
      bits = {$urandom, $urandom, $urandom, $urandom};
      w = bits[$bits(savh_pkg::req_item_type)-1:0];
      w.kind = savh_pkg::KIND_SAMPLE;
      case (mix)
         MIX_HIGH: begin
            w.chamber_tvoc = '1;
            w.chamber_eco2 = '1;
            w.chamber_temp = 8'sd127;
            w.chamber_rh   = '1;
            w.room_tvoc    = '1;
            w.room_eco2    = '1;
            w.room_temp    = 8'sd127;
            w.room_rh      = '1;
         end
         MIX_LOW: begin
            w.chamber_tvoc = '0;
            w.chamber_eco2 = '0;
            w.chamber_temp = -8'sd128;
            w.chamber_rh   = '0;
            w.room_tvoc    = '0;
            w.room_eco2    = '0;
            w.room_temp    = -8'sd128;
            w.room_rh      = '0;
         end
         MIX_NEAR_ZERO: begin
            // small signed sums so that truncation toward zero shows
            w.chamber_temp = 8'($urandom_range(0, 4) - 2);
            w.room_temp    = 8'($urandom_range(0, 4) - 2);
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic savh_pkg::req_item_type read_word(input int age);
      logic [127:0]           bits;
      savh_pkg::req_item_type w;
      bits = {$urandom, $urandom, $urandom, $urandom};
      w = bits[$bits(savh_pkg::req_item_type)-1:0];
      w.kind = savh_pkg::KIND_READ;
      w.age_index = 5'(age);
      return w;
   endfunction

   function automatic void queue_word(input savh_pkg::req_item_type w);
      sensor_words.push_back(w);
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
      end
   endtask

   // stimulus
   initial begin
      savh_pkg::req_item_type w;
      mix_type                mix;
      int                     samples_made;
      int                     held;
      int                     age;
      samples_made = 0;
      flow_sum = '{default: 0};
      temp_sum = '{default: 0};
      rh_sum = '{default: 0};
      samples_taken = 0;
      next_slot = 0;
      points_held = 0;

      // empty ring, ages beyond the depth, ignored fields
      queue_word(read_word(0));
      queue_word(read_word(31));
      queue_word(read_word(29));
      queue_word(read_word(30));
      w = sample_word(MIX_HIGH);
      w.kind = savh_pkg::KIND_READ;
      w.age_index = '0;
      queue_word(w);
      queue_word(sample_word(MIX_HIGH));
      queue_word(sample_word(MIX_LOW));
      w = sample_word(MIX_NEAR_ZERO);
      w.age_index = '1;
      queue_word(w);
      w = sample_word(MIX_HIGH);
      w.chamber_temp = -8'sd128;
      w.chamber_eco2 = '0;
      w.room_rh = '0;
      queue_word(w);
      w = sample_word(MIX_LOW);
      w.room_temp = 8'sd127;
      w.room_tvoc = '1;
      w.chamber_rh = 7'd100;
      queue_word(w);
      samples_made = 5;

      // whole points with random content, enough to wrap the ring, reads scattered
      while (samples_made < 32 * SPP) begin
         mix = mix_type'($urandom_range(0, 3));
         if ($urandom_range(0, 1) == 0) mix = MIX_RANDOM;
         repeat (SPP) begin
            while ($urandom_range(0, 31) == 0) begin
               held = (samples_made / SPP < HIST) ? samples_made / SPP : HIST;
               if ($urandom_range(0, 1) == 0)
                  age = $urandom_range(0, 31);
               else
                  age = held + $urandom_range(0, 3) - 2;
               if (age < 0) age = 0;
               if (age > 31) age = 31;
               queue_word(read_word(age));
            end
            queue_word(sample_word(mix));
            samples_made++;
         end
      end
      for (int a = 0; a < 32; a++) queue_word(read_word(a));
      total_words = sensor_words.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (words_accepted == total_words);
      while (predicted_results.size() > 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   // request driver
   always @(negedge clock) begin : drive_requests
      logic                   next_valid;
      savh_pkg::req_item_type next_word;
      bit                     calm;
      next_valid = req_valid;
      next_word = req_word;
      calm = (total_words - words_accepted) < 150;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_valid || req_taken) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (sensor_words.size() > 0) begin
            if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 6);
            end else begin
               next_valid = 1'b1;
               next_word = sensor_words.pop_front();
            end
         end
      end
      req_valid <= next_valid;
      req_word <= next_word;
   end

   // result receiver
   always @(negedge clock) begin : drive_ready
      bit calm;
      calm = (total_words - words_accepted) < 150;
      if (reset || hold_left > 0) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one long hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (!hold_done && words_accepted == 700) begin
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin : watch_words
      savh_pkg::rsp_item_type want;
      savh_pkg::rsp_item_type got;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_ready) begin
            got = rsp_bus.payload;
            results_seen++;
            if (predicted_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d arrived with nothing expected", results_seen);
            end else begin
               want = predicted_results.pop_front();
               check_field("avg_chamber_tvoc", want.avg_chamber_tvoc, got.avg_chamber_tvoc);
               check_field("avg_chamber_eco2", want.avg_chamber_eco2, got.avg_chamber_eco2);
               check_field("avg_chamber_temp", want.avg_chamber_temp, got.avg_chamber_temp);
               check_field("avg_chamber_rh", want.avg_chamber_rh, got.avg_chamber_rh);
               check_field("avg_room_tvoc", want.avg_room_tvoc, got.avg_room_tvoc);
               check_field("avg_room_eco2", want.avg_room_eco2, got.avg_room_eco2);
               check_field("avg_room_temp", want.avg_room_temp, got.avg_room_temp);
               check_field("avg_room_rh", want.avg_room_rh, got.avg_room_rh);
               check_field("point_written", want.point_written, got.point_written);
               check_field("entry_valid", want.entry_valid, got.entry_valid);
               check_field("points_stored", want.points_stored, got.points_stored);
               check_field("samples_pending", want.samples_pending, got.samples_pending);
            end
         end
         if (req_valid && req_bus.ready) begin
            predicted_results.push_back(average_and_store(req_word));
            words_accepted <= words_accepted + 1;
            req_taken <= 1'b1;
         end else begin
            req_taken <= 1'b0;
         end
      end
   end

endmodule

### sensor_average_history_unit.f
+incdir+rtl/core
rtl/core/savh_pkg.sv
rtl/core/savh_stream_if.sv
rtl/core/savh_ram.sv
rtl/core/savh_queue.sv
rtl/core/savh_front.sv
rtl/core/savh_back.sv
rtl/core/sensor_average_history_unit.sv
test/sensor_average_history_unit_tb.sv
